// ----- rtl/alu8f_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package alu8f_pkg;

    localparam logic [4:0] MODE_ADD   = 5'd0;
    localparam logic [4:0] MODE_ADC   = 5'd1;
    localparam logic [4:0] MODE_SUB   = 5'd2;
    localparam logic [4:0] MODE_SBC   = 5'd3;
    localparam logic [4:0] MODE_AND   = 5'd4;
    localparam logic [4:0] MODE_XOR   = 5'd5;
    localparam logic [4:0] MODE_OR    = 5'd6;
    localparam logic [4:0] MODE_CP    = 5'd7;
    localparam logic [4:0] MODE_INC   = 5'd8;
    localparam logic [4:0] MODE_DEC   = 5'd9;
    localparam logic [4:0] MODE_RLC   = 5'd10;
    localparam logic [4:0] MODE_RRC   = 5'd11;
    localparam logic [4:0] MODE_RL    = 5'd12;
    localparam logic [4:0] MODE_RR    = 5'd13;
    localparam logic [4:0] MODE_SLA   = 5'd14;
    localparam logic [4:0] MODE_SRA   = 5'd15;
    localparam logic [4:0] MODE_SWAP  = 5'd16;
    localparam logic [4:0] MODE_SRL   = 5'd17;
    localparam logic [4:0] MODE_BIT   = 5'd18;
    localparam logic [4:0] MODE_RES   = 5'd19;
    localparam logic [4:0] MODE_SET   = 5'd20;
    localparam logic [4:0] MODE_DAA   = 5'd21;
    localparam logic [4:0] MODE_CPL   = 5'd22;
    localparam logic [4:0] MODE_SCF   = 5'd23;
    localparam logic [4:0] MODE_CCF   = 5'd24;
    localparam logic [4:0] MODE_ADD16 = 5'd25;
    localparam logic [4:0] MODE_ADDSP = 5'd26;
    localparam logic [4:0] MODE_RLCA  = 5'd27;
    localparam logic [4:0] MODE_RRCA  = 5'd28;
    localparam logic [4:0] MODE_RLA   = 5'd29;
    localparam logic [4:0] MODE_RRA   = 5'd30;

    localparam logic [7:0] DAA_LIMIT    = 8'h99;
    localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
    localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
    localparam logic [3:0] DAA_NIBBLE   = 4'h9;

    typedef struct packed {
        logic [4:0]  mode;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  bit_index;
        logic        zero_in;
        logic        subtract_in;
        logic        half_in;
        logic        carry_in;
    } t_alu_req;

    typedef struct packed {
        logic [15:0] result;
        logic        write_back;
        logic        zero_out;
        logic        subtract_out;
        logic        half_out;
        logic        carry_out;
    } t_alu_rsp;

endpackage

`default_nettype wire

// ----- rtl/eight_bit_alu_with_flags.sv -----
// Eight-bit ALU with Z/N/H/C flags and 16-bit add modes.
// An accepted request is held in the input register; its result is valid once it reaches the result register.
// Throughput: one request per cycle while the output is not stalled; an input register and a result register
// form the pipeline, and stall from the output travels back to the input.
// Reset (synchronous, active low) empties both pipeline stages.
`timescale 1ns / 1ps
`default_nettype none

module eight_bit_alu_with_flags
    import alu8f_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_alu_req i_in,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_alu_rsp      o_out
);

    logic     r_in_valid;
    t_alu_req r_in;
    logic     r_out_valid;
    t_alu_rsp r_out;
    t_alu_rsp n_out;
    logic     out_ready;
    logic     in_ready;

    assign out_ready   = !r_out_valid || !i_out_stall;
    assign in_ready    = !r_in_valid || out_ready;
    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
        if (in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (out_ready && r_in_valid) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  v;
        logic [7:0]  r8;
        logic [7:0]  mask;
        logic [8:0]  sum9;
        logic [4:0]  nib5;
        logic [16:0] sum17;
        logic [12:0] sum13;
        logic [15:0] off16;
        logic        ci;
        logic        z;
        logic        n;
        logic        h;
        logic        c;
        logic        wb;
        logic        setz;
        logic        wide;

        a     = r_in.operand_a[7:0];
        b     = r_in.operand_b[7:0];
        z     = r_in.zero_in;
        n     = r_in.subtract_in;
        h     = r_in.half_in;
        c     = r_in.carry_in;
        ci    = 1'b0;
        r8    = 8'h00;
        wb    = 1'b1;
        setz  = 1'b1;
        wide  = 1'b0;
        sum9  = 9'd0;
        nib5  = 5'd0;
        sum17 = 17'd0;
        sum13 = 13'd0;
        off16 = 16'd0;
        mask  = 8'h01 << r_in.bit_index;
        v     = (r_in.mode >= MODE_RLCA) ? a : b;

        unique case (r_in.mode) inside
            MODE_ADD, MODE_ADC: begin
                ci   = (r_in.mode == MODE_ADC) ? r_in.carry_in : 1'b0;
                sum9 = {1'b0, a} + {1'b0, b} + {8'd0, ci};
                nib5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};
                r8   = sum9[7:0];
                n    = 1'b0;
                h    = nib5[4];
                c    = sum9[8];
            end
            MODE_SUB, MODE_SBC, MODE_CP: begin
                ci   = (r_in.mode == MODE_SBC) ? r_in.carry_in : 1'b0;
                sum9 = {1'b0, a} - {1'b0, b} - {8'd0, ci};
                nib5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci};
                r8   = sum9[7:0];
                n    = 1'b1;
                h    = nib5[4];
                c    = sum9[8];
                wb   = (r_in.mode != MODE_CP);
            end
            MODE_AND: begin
                r8 = a & b;
                n  = 1'b0;
                h  = 1'b1;
                c  = 1'b0;
            end
            MODE_XOR: begin
                r8 = a ^ b;
                n  = 1'b0;
                h  = 1'b0;
                c  = 1'b0;
            end
            MODE_OR: begin
                r8 = a | b;
                n  = 1'b0;
                h  = 1'b0;
                c  = 1'b0;
            end
            MODE_INC: begin
                r8 = b + 8'd1;
                n  = 1'b0;
                h  = (b[3:0] == 4'hf);
            end
            MODE_DEC: begin
                r8 = b - 8'd1;
                n  = 1'b1;
                h  = (b[3:0] == 4'h0);
            end
            MODE_RLC, MODE_RLCA: begin
                r8 = {v[6:0], v[7]};
                c  = v[7];
            end
            MODE_RRC, MODE_RRCA: begin
                r8 = {v[0], v[7:1]};
                c  = v[0];
            end
            MODE_RL, MODE_RLA: begin
                r8 = {v[6:0], r_in.carry_in};
                c  = v[7];
            end
            MODE_RR, MODE_RRA: begin
                r8 = {r_in.carry_in, v[7:1]};
                c  = v[0];
            end
            MODE_SLA: begin
                r8 = {v[6:0], 1'b0};
                c  = v[7];
            end
            MODE_SRA: begin
                r8 = {v[7], v[7:1]};
                c  = v[0];
            end
            MODE_SWAP: begin
                r8 = {v[3:0], v[7:4]};
                c  = 1'b0;
            end
            MODE_SRL: begin
                r8 = {1'b0, v[7:1]};
                c  = v[0];
            end
            MODE_BIT: begin
                r8   = b;
                wb   = 1'b0;
                setz = 1'b0;
                z    = !(|(b & mask));
                n    = 1'b0;
                h    = 1'b1;
            end
            MODE_RES: begin
                r8   = b & ~mask;
                setz = 1'b0;
            end
            MODE_SET: begin
                r8   = b | mask;
                setz = 1'b0;
            end
            MODE_DAA: begin
                r8 = b;
                if (!r_in.subtract_in) begin
                    if (r_in.carry_in || (b > DAA_LIMIT)) begin
                        r8 = r8 + DAA_HIGH_ADJ;
                        c  = 1'b1;
                    end
                    if (r_in.half_in || (b[3:0] > DAA_NIBBLE)) begin
                        r8 = r8 + DAA_LOW_ADJ;
                    end
                end else begin
                    if (r_in.carry_in) begin
                        r8 = r8 - DAA_HIGH_ADJ;
                    end
                    if (r_in.half_in) begin
                        r8 = r8 - DAA_LOW_ADJ;
                    end
                end
                h = 1'b0;
            end
            MODE_CPL: begin
                r8   = ~b;
                n    = 1'b1;
                h    = 1'b1;
                setz = 1'b0;
            end
            MODE_SCF: begin
                wb   = 1'b0;
                setz = 1'b0;
                n    = 1'b0;
                h    = 1'b0;
                c    = 1'b1;
            end
            MODE_CCF: begin
                wb   = 1'b0;
                setz = 1'b0;
                n    = 1'b0;
                h    = 1'b0;
                c    = !r_in.carry_in;
            end
            MODE_ADD16: begin
                wide  = 1'b1;
                sum17 = {1'b0, r_in.operand_a} + {1'b0, r_in.operand_b};
                sum13 = {1'b0, r_in.operand_a[11:0]} + {1'b0, r_in.operand_b[11:0]};
                setz  = 1'b0;
                n     = 1'b0;
                h     = sum13[12];
                c     = sum17[16];
            end
            MODE_ADDSP: begin
                wide  = 1'b1;
                off16 = {{8{b[7]}}, b};
                sum17 = {1'b0, r_in.operand_a + off16};
                nib5  = {1'b0, r_in.operand_a[3:0]} + {1'b0, b[3:0]};
                sum9  = {1'b0, a} + {1'b0, b};
                setz  = 1'b0;
                z     = 1'b0;
                n     = 1'b0;
                h     = nib5[4];
                c     = sum9[8];
            end
            default: begin
                wb   = 1'b0;
                setz = 1'b0;
            end
        endcase

        if (r_in.mode >= MODE_RLCA && r_in.mode <= MODE_RRA) begin
            setz = 1'b0;
            z    = 1'b0;
            n    = 1'b0;
            h    = 1'b0;
        end else if (r_in.mode >= MODE_RLC && r_in.mode <= MODE_SRL) begin
            n = 1'b0;
            h = 1'b0;
        end

        if (setz) begin
            z = (r8 == 8'h00);
        end

        n_out.result       = wide ? sum17[15:0] : {8'h00, r8};
        n_out.write_back   = wb;
        n_out.zero_out     = z;
        n_out.subtract_out = n;
        n_out.half_out     = h;
        n_out.carry_out    = c;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("Input stalled while the pipeline has room.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in_valid)
        else $error("Accepted request did not enter the input register.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_ready) |=> r_out_valid)
        else $error("Request left the input register without reaching the result register.");

    assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_in_valid && !r_out_valid))
        else $error("Pipeline not empty after reset.");

endmodule

`default_nettype wire
